// ===== design/stdr_pkg.sv =====
// Package of the scanline depth rasterizer: widths, codes, reset values,
// sequencer states and the control structs shared by the modules.
// Depends on nothing; every other file of the block imports it.
package stdr_pkg;

	// Defaults of the top-level parameters.
	localparam int MAX_LINE_PIXELS_DEF  = 2048;
	localparam int TRIANGLE_ID_BITS_DEF = 16;

	// Fixed field widths.
	localparam int COORD_W    = 32;
	localparam int LW_W       = 12;
	localparam int HS_W       = 31;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// Action codes of an input transaction.
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_DRAW  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SCALE = 4'd1;

	// Register reset values.
	localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 12'd1920;
	localparam logic [HS_W-1:0] HALF_SCALE_RESET = 31'd35389440;

	// Fixed-point constants.
	localparam logic signed [31:0] DEPTH_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [32:0] ONE_Q16   = 33'sd65536;
	localparam logic [15:0]        ROUND_UP  = 16'hFFFF;

	// Shared divider geometry.
	localparam int DIV_DVD_W       = 64;
	localparam int DIV_DVS_W       = 33;
	localparam int DIV_Q_W         = 48;
	localparam int DIV_SHORT_STEPS = 31;
	localparam int DIV_LONG_STEPS  = 48;
	localparam int DIV_CNT_W       = 6;

	// Shared multiplier geometry.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 31;
	localparam int MUL_P_W = 64;

	// Width of a span end in Q32.16 pixel units.
	localparam int XW = 48;

	typedef struct packed {
		logic                 start;
		logic                 long_mode;
		logic [DIV_DVD_W-1:0] dividend;
		logic [DIV_DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_Q_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_EDGE_SETUP,
		ST_EDGE_DIV,
		ST_EDGE_MX,
		ST_EDGE_MZ,
		ST_EDGE_END,
		ST_PAIR_SETUP,
		ST_DEPTH_START,
		ST_DEPTH_DIV,
		ST_XA_MUL,
		ST_XB_MUL,
		ST_XB_GET,
		ST_SPAN_SETUP,
		ST_SPAN_RANGE,
		ST_SPAN_NORM,
		ST_PIX_START,
		ST_PIX_DIV,
		ST_PIX_MUL,
		ST_PIX_Z,
		ST_PIX_WR,
		ST_PAIR_NEXT
	} state_t;

endpackage

// ===== design/stdr_if.sv =====
// Handshake interfaces of the scanline depth rasterizer: the input item
// channel, the result channel and the configuration write channel.
// Depends on stdr_pkg.
interface stdr_item_if import stdr_pkg::*; #(
	parameter int ID_BITS = TRIANGLE_ID_BITS_DEF
) ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic signed [COORD_W-1:0] line_y;
	logic signed [COORD_W-1:0] vertex0_x;
	logic signed [COORD_W-1:0] vertex0_y;
	logic signed [COORD_W-1:0] vertex0_z;
	logic signed [COORD_W-1:0] vertex1_x;
	logic signed [COORD_W-1:0] vertex1_y;
	logic signed [COORD_W-1:0] vertex1_z;
	logic signed [COORD_W-1:0] vertex2_x;
	logic signed [COORD_W-1:0] vertex2_y;
	logic signed [COORD_W-1:0] vertex2_z;
	logic [ID_BITS-1:0]        triangle_id;

	modport source (
		output valid, action, line_y, vertex0_x, vertex0_y, vertex0_z,
		output vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z,
		output triangle_id,
		input  ready
	);
	modport sink (
		input  valid, action, line_y, vertex0_x, vertex0_y, vertex0_z,
		input  vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z,
		input  triangle_id,
		output ready
	);
endinterface

interface stdr_result_if import stdr_pkg::*; #(
	parameter int COL_BITS   = $clog2(MAX_LINE_PIXELS_DEF),
	parameter int OWNER_BITS = TRIANGLE_ID_BITS_DEF + 1
) ();
	logic                      valid;
	logic                      ready;
	logic [COL_BITS-1:0]       pixel_column;
	logic signed [OWNER_BITS-1:0] pixel_owner;
	logic signed [COORD_W-1:0] pixel_depth;
	logic                      last_pixel;

	modport source (
		output valid, pixel_column, pixel_owner, pixel_depth, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_column, pixel_owner, pixel_depth, last_pixel,
		output ready
	);
endinterface

interface stdr_cfg_if import stdr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/scanline_triangle_depth_raster.sv =====
// Top level of the scanline depth rasterizer; uses stdr_pkg, stdr_if,
// stdr_div and stdr_line_mem.
//
// The block holds the depth and owner of every pixel of one scanline and
// takes one transaction at a time. A clear sweeps the line store one pixel a
// cycle, and the same sweep runs after reset before the first transaction
// is taken. A read passes through an address state and a data state and
// then waits for the result register to drain. A draw works under a
// sequencer that shares one bit-per-cycle divider and one 33x31 multiplier:
// each span is halved until its width fits in 33 bits, and each covered
// pixel takes a 31-step divide of its position fraction, skipped for a
// flat span, followed by the read-modify-write of the line store.
// Configuration writes are taken at any time and meant for idle periods.
module scanline_triangle_depth_raster import stdr_pkg::*; #(
	parameter int MAX_LINE_PIXELS  = MAX_LINE_PIXELS_DEF,
	parameter int TRIANGLE_ID_BITS = TRIANGLE_ID_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	stdr_item_if.sink    item,
	stdr_result_if.source result,
	stdr_cfg_if.sink     cfg
);

	localparam int COL_W = $clog2(MAX_LINE_PIXELS);
	localparam int OWN_W = TRIANGLE_ID_BITS + 1;
	localparam int WW    = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;

	state_t state_q, state_d;

	// Configuration registers.
	logic [LW_W-1:0] line_width_q;
	logic [HS_W-1:0] half_scale_q;

	// Latched item.
	logic signed [31:0] y_q;
	logic signed [31:0] vx_q [3];
	logic signed [31:0] vy_q [3];
	logic signed [31:0] vz_q [3];
	logic [TRIANGLE_ID_BITS-1:0] tid_q;

	// Edge crossings, in edge order after the edge pass.
	logic               ok_q [3];
	logic signed [31:0] cx_q [3];
	logic signed [31:0] cz_q [3];
	logic signed [31:0] cx_tmp_q;

	// Sequencer counters and span state.
	logic [1:0]           cnt_q;
	logic                 sel_q;
	logic signed [31:0]   za_q, zb_q, z_q;
	logic signed [XW-1:0] xa_q, xb_q;
	logic signed [XW:0]   lo_q, hi_q;
	logic [XW-1:0]        span_q;
	logic [3:0]           k_q;
	logic [COL_W-1:0]     j_q, last_q;

	// Read pointer and result register.
	logic [COL_W-1:0]        rp_q;
	logic [COL_W-1:0]        rd_col_q;
	logic                    rd_last_q;
	logic                    out_valid_q;
	logic [COL_W-1:0]        out_col_q;
	logic [OWN_W-1:0]        out_owner_q;
	logic signed [31:0]      out_depth_q;
	logic                    out_last_q;

	// Shared units.
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod_q;

	mem_ctl_t           mem_ctl;
	logic [COL_W-1:0]   mem_rd_addr, mem_wr_addr;
	logic signed [31:0] mem_wr_depth, mem_rd_depth;
	logic [OWN_W-1:0]   mem_wr_owner, mem_rd_owner;

	logic item_fire;
	logic slot_free;

	// Effective width and read column.
	logic [WW-1:0]    lw_ext, eff_w, eff_w_m1;
	logic [COL_W-1:0] rd_p;
	logic             rd_last;

	always_comb begin
		lw_ext = WW'(line_width_q);
		if (lw_ext == '0)
			eff_w = WW'(1);
		else if (lw_ext > WW'(MAX_LINE_PIXELS))
			eff_w = WW'(MAX_LINE_PIXELS);
		else
			eff_w = lw_ext;
		eff_w_m1 = eff_w - 1'b1;
		rd_p     = (WW'(rp_q) >= eff_w) ? '0 : rp_q;
		rd_last  = WW'(rd_p) == eff_w_m1;
	end

	// Edge arithmetic on the current edge, from vertex 0 to vertex 1.
	logic signed [32:0] e_n, e_d, e_dx, e_dz;
	logic [32:0]        e_n_mag, e_d_mag, e_dx_mag, e_dz_mag;
	logic               e_valid;
	logic signed [33:0] e_step, e_cx_sum, e_cz_sum;

	always_comb begin
		e_n  = 33'(y_q) - 33'(vy_q[0]);
		e_d  = 33'(vy_q[1]) - 33'(vy_q[0]);
		e_dx = 33'(vx_q[1]) - 33'(vx_q[0]);
		e_dz = 33'(vz_q[1]) - 33'(vz_q[0]);
		e_n_mag  = e_n[32]  ? 33'(-e_n)  : 33'(e_n);
		e_d_mag  = e_d[32]  ? 33'(-e_d)  : 33'(e_d);
		e_dx_mag = e_dx[32] ? 33'(-e_dx) : 33'(e_dx);
		e_dz_mag = e_dz[32] ? 33'(-e_dz) : 33'(e_dz);
		if (e_d == '0)
			e_valid = 1'b0;
		else if (e_d[32])
			e_valid = (e_n <= 0) && (e_n >= e_d);
		else
			e_valid = (e_n >= 0) && (e_n <= e_d);
		e_step   = $signed({1'b0, prod_q[62:30]});
		e_cx_sum = 34'(vx_q[0]) + (e_dx[32] ? -e_step : e_step);
		e_cz_sum = 34'(vz_q[0]) + (e_dz[32] ? -e_step : e_step);
	end

	// Endpoint depth and span ends.
	logic signed [31:0]  cz_sel;
	logic signed [32:0]  den;
	logic                den_ok;
	logic [31:0]         q_depth;
	logic [32:0]         cx0_mag, cx1_mag;
	logic signed [63:0]  prod_pos, prod_neg;

	always_comb begin
		cz_sel   = sel_q ? cz_q[1] : cz_q[0];
		den      = 33'(cz_sel) - ONE_Q16;
		den_ok   = (den > 0) && (half_scale_q != '0);
		q_depth  = (div_rsp.quotient > DIV_Q_W'(DEPTH_MAX)) ? DEPTH_MAX
		                                                   : div_rsp.quotient[31:0];
		cx0_mag  = cx_q[0][31] ? 33'(-33'(cx_q[0])) : 33'(cx_q[0]);
		cx1_mag  = cx_q[1][31] ? 33'(-33'(cx_q[1])) : 33'(cx_q[1]);
		prod_pos = $signed(prod_q);
		prod_neg = -prod_pos;
	end

	// Span setup, range and per-pixel position.
	logic                 sw;
	logic signed [XW:0]   s_lo, s_hi, s_diff;
	logic signed [49:0]   first_sum;
	logic signed [33:0]   first_raw, last_raw, first_c, last_c, w_last;
	logic                 span_empty;
	logic signed [49:0]   pos_full;
	logic [XW-1:0]        pos_sh;
	logic                 flat;
	logic signed [32:0]   p_dz;
	logic [32:0]          p_dz_mag;
	logic signed [33:0]   p_step, p_z_sum;

	always_comb begin
		sw     = xa_q > xb_q;
		s_lo   = (XW+1)'(sw ? xb_q : xa_q) + (XW+1)'(half_scale_q);
		s_hi   = (XW+1)'(sw ? xa_q : xb_q) + (XW+1)'(half_scale_q);
		s_diff = s_hi - s_lo;

		first_sum = 50'(lo_q) + 50'(ROUND_UP);
		first_raw = first_sum[49:16];
		last_raw  = 34'($signed(hi_q[XW:16]));
		w_last    = 34'(eff_w_m1);
		first_c   = first_raw[33] ? '0 : first_raw;
		last_c    = (last_raw > w_last) ? w_last : last_raw;
		span_empty = first_c > last_c;

		pos_full = $signed(50'({j_q, 16'h0})) - 50'(lo_q);
		pos_sh   = pos_full[XW-1:0] >> k_q;
		flat     = span_q == '0;

		p_dz     = 33'(zb_q) - 33'(za_q);
		p_dz_mag = p_dz[32] ? 33'(-p_dz) : 33'(p_dz);
		p_step   = $signed({1'b0, prod_q[62:30]});
		p_z_sum  = 34'(za_q) + (p_dz[32] ? -p_step : p_step);
	end

	assign item_fire = item.valid && item.ready;
	assign slot_free = !out_valid_q || result.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (j_q == COL_W'(MAX_LINE_PIXELS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item.valid) begin
					case (item.action)
						ACT_CLEAR: state_d = ST_CLEAR;
						ACT_DRAW:  state_d = ST_EDGE_SETUP;
						ACT_READ:  state_d = ST_RD_ADDR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_ADDR: state_d = ST_RD_DATA;
			ST_RD_DATA: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_EDGE_SETUP: begin
				if (e_valid) state_d = ST_EDGE_DIV;
				else if (cnt_q == 2'd2) state_d = ST_PAIR_SETUP;
			end
			ST_EDGE_DIV: begin
				if (div_rsp.done) state_d = ST_EDGE_MX;
			end
			ST_EDGE_MX: state_d = ST_EDGE_MZ;
			ST_EDGE_MZ: state_d = ST_EDGE_END;
			ST_EDGE_END: state_d = (cnt_q == 2'd2) ? ST_PAIR_SETUP : ST_EDGE_SETUP;
			ST_PAIR_SETUP: state_d = (ok_q[0] && ok_q[1]) ? ST_DEPTH_START : ST_PAIR_NEXT;
			ST_DEPTH_START: state_d = den_ok ? ST_DEPTH_DIV : ST_PAIR_NEXT;
			ST_DEPTH_DIV: begin
				if (div_rsp.done) begin
					if (div_rsp.quotient == '0) state_d = ST_PAIR_NEXT;
					else if (sel_q) state_d = ST_XA_MUL;
					else state_d = ST_DEPTH_START;
				end
			end
			ST_XA_MUL:     state_d = ST_XB_MUL;
			ST_XB_MUL:     state_d = ST_XB_GET;
			ST_XB_GET:     state_d = ST_SPAN_SETUP;
			ST_SPAN_SETUP: state_d = ST_SPAN_RANGE;
			ST_SPAN_RANGE: state_d = span_empty ? ST_PAIR_NEXT : ST_SPAN_NORM;
			ST_SPAN_NORM: begin
				if (span_q[XW-1:DIV_DVS_W] == '0) state_d = ST_PIX_START;
			end
			ST_PIX_START: state_d = flat ? ST_PIX_MUL : ST_PIX_DIV;
			ST_PIX_DIV: begin
				if (div_rsp.done) state_d = ST_PIX_MUL;
			end
			ST_PIX_MUL: state_d = ST_PIX_Z;
			ST_PIX_Z:   state_d = ST_PIX_WR;
			ST_PIX_WR:  state_d = (j_q == last_q) ? ST_PAIR_NEXT : ST_PIX_START;
			ST_PAIR_NEXT: state_d = (cnt_q == 2'd2) ? ST_IDLE : ST_PAIR_SETUP;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, divider, multiplier and line store.
	always_comb begin
		item.ready       = state_q == ST_IDLE;
		div_req.start    = 1'b0;
		div_req.long_mode = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		mul_a            = '0;
		mul_b            = '0;
		mem_ctl.rd_en    = 1'b0;
		mem_ctl.wr_en    = 1'b0;
		mem_rd_addr      = j_q;
		mem_wr_addr      = j_q;
		mem_wr_depth     = z_q;
		mem_wr_owner     = {1'b0, tid_q};
		case (state_q)
			ST_CLEAR: begin
				mem_ctl.wr_en = 1'b1;
				mem_wr_depth  = DEPTH_MAX;
				mem_wr_owner  = '1;
			end
			ST_RD_ADDR: begin
				mem_ctl.rd_en = 1'b1;
				mem_rd_addr   = rd_p;
			end
			ST_EDGE_SETUP: begin
				div_req.start    = e_valid;
				div_req.dividend = 64'({e_n_mag, 30'h0});
				div_req.divisor  = e_d_mag;
			end
			ST_EDGE_MX: begin
				mul_a = e_dx_mag;
				mul_b = div_rsp.quotient[MUL_B_W-1:0];
			end
			ST_EDGE_MZ: begin
				mul_a = e_dz_mag;
				mul_b = div_rsp.quotient[MUL_B_W-1:0];
			end
			ST_DEPTH_START: begin
				div_req.start     = den_ok;
				div_req.long_mode = 1'b1;
				div_req.dividend  = 64'({half_scale_q, 16'h0});
				div_req.divisor   = den;
			end
			ST_XA_MUL: begin
				mul_a = cx0_mag;
				mul_b = half_scale_q;
			end
			ST_XB_MUL: begin
				mul_a = cx1_mag;
				mul_b = half_scale_q;
			end
			ST_PIX_START: begin
				mem_ctl.rd_en    = 1'b1;
				div_req.start    = !flat;
				div_req.dividend = {1'b0, pos_sh[DIV_DVS_W-1:0], 30'h0};
				div_req.divisor  = span_q[DIV_DVS_W-1:0];
			end
			ST_PIX_MUL: begin
				mul_a = p_dz_mag;
				mul_b = div_rsp.quotient[MUL_B_W-1:0];
			end
			ST_PIX_WR: begin
				mem_ctl.wr_en = z_q < mem_rd_depth;
			end
			default: ;
		endcase
	end

	// State, counters, configuration and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			line_width_q <= LINE_WIDTH_RESET;
			half_scale_q <= HALF_SCALE_RESET;
			j_q          <= '0;
			cnt_q        <= '0;
			rp_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid) begin
				case (cfg.index)
					REG_LINE_WIDTH: line_width_q <= cfg.data[LW_W-1:0];
					REG_HALF_SCALE: half_scale_q <= cfg.data[HS_W-1:0];
					default: ;
				endcase
			end

			if (state_q == ST_RD_DATA && slot_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_CLEAR: begin
					j_q <= j_q + 1'b1;
					if (j_q == COL_W'(MAX_LINE_PIXELS - 1)) rp_q <= '0;
				end
				ST_IDLE: begin
					j_q   <= '0;
					cnt_q <= '0;
				end
				ST_RD_ADDR: rp_q <= rd_last ? '0 : rd_p + 1'b1;
				ST_EDGE_SETUP: begin
					if (!e_valid) cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 1'b1;
				end
				ST_EDGE_END: cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 1'b1;
				ST_SPAN_RANGE: j_q <= first_c[COL_W-1:0];
				ST_PIX_WR: begin
					if (j_q != last_q) j_q <= j_q + 1'b1;
				end
				ST_PAIR_NEXT: cnt_q <= cnt_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Shared multiplier with its product register.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (item_fire) begin
			y_q     <= item.line_y;
			vx_q[0] <= item.vertex0_x;
			vy_q[0] <= item.vertex0_y;
			vz_q[0] <= item.vertex0_z;
			vx_q[1] <= item.vertex1_x;
			vy_q[1] <= item.vertex1_y;
			vz_q[1] <= item.vertex1_z;
			vx_q[2] <= item.vertex2_x;
			vy_q[2] <= item.vertex2_y;
			vz_q[2] <= item.vertex2_z;
			tid_q   <= item.triangle_id;
		end

		case (state_q)
			ST_RD_ADDR: begin
				rd_col_q  <= rd_p;
				rd_last_q <= rd_last;
			end
			ST_RD_DATA: begin
				if (slot_free) begin
					out_col_q   <= rd_col_q;
					out_owner_q <= mem_rd_owner;
					out_depth_q <= mem_rd_depth;
					out_last_q  <= rd_last_q;
				end
			end
			ST_EDGE_SETUP: begin
				// An edge that misses the line enters the crossing list as invalid,
				// so the crossing slots stay aligned with the edge order.
				if (!e_valid) begin
					ok_q[0] <= ok_q[1];
					ok_q[1] <= ok_q[2];
					ok_q[2] <= 1'b0;
					cx_q[0] <= cx_q[1]; cx_q[1] <= cx_q[2]; cx_q[2] <= cx_q[0];
					cz_q[0] <= cz_q[1]; cz_q[1] <= cz_q[2]; cz_q[2] <= cz_q[0];
					vx_q[0] <= vx_q[1]; vx_q[1] <= vx_q[2]; vx_q[2] <= vx_q[0];
					vy_q[0] <= vy_q[1]; vy_q[1] <= vy_q[2]; vy_q[2] <= vy_q[0];
					vz_q[0] <= vz_q[1]; vz_q[1] <= vz_q[2]; vz_q[2] <= vz_q[0];
				end
			end
			ST_EDGE_MZ: cx_tmp_q <= e_cx_sum[31:0];
			ST_EDGE_END: begin
				ok_q[0] <= ok_q[1];
				ok_q[1] <= ok_q[2];
				ok_q[2] <= 1'b1;
				cx_q[0] <= cx_q[1];
				cx_q[1] <= cx_q[2];
				cx_q[2] <= cx_tmp_q;
				cz_q[0] <= cz_q[1];
				cz_q[1] <= cz_q[2];
				cz_q[2] <= e_cz_sum[31:0];
				vx_q[0] <= vx_q[1]; vx_q[1] <= vx_q[2]; vx_q[2] <= vx_q[0];
				vy_q[0] <= vy_q[1]; vy_q[1] <= vy_q[2]; vy_q[2] <= vy_q[0];
				vz_q[0] <= vz_q[1]; vz_q[1] <= vz_q[2]; vz_q[2] <= vz_q[0];
			end
			ST_PAIR_SETUP: sel_q <= 1'b0;
			ST_DEPTH_DIV: begin
				if (div_rsp.done) begin
					if (sel_q) zb_q <= q_depth;
					else za_q <= q_depth;
					sel_q <= 1'b1;
				end
			end
			ST_XB_MUL: xa_q <= cx_q[0][31] ? prod_neg[63:16] : prod_pos[63:16];
			ST_XB_GET: xb_q <= cx_q[1][31] ? prod_neg[63:16] : prod_pos[63:16];
			ST_SPAN_SETUP: begin
				// Order the ends by x and carry their depths along.
				lo_q   <= s_lo;
				hi_q   <= s_hi;
				span_q <= s_diff[XW-1:0];
				k_q    <= '0;
				if (sw) begin
					za_q <= zb_q;
					zb_q <= za_q;
				end
			end
			ST_SPAN_RANGE: last_q <= last_c[COL_W-1:0];
			ST_SPAN_NORM: begin
				if (span_q[XW-1:DIV_DVS_W] != '0) begin
					span_q <= span_q >> 1;
					k_q    <= k_q + 1'b1;
				end
			end
			ST_PIX_Z: z_q <= flat ? za_q : p_z_sum[31:0];
			ST_PAIR_NEXT: begin
				ok_q[0] <= ok_q[1]; ok_q[1] <= ok_q[2]; ok_q[2] <= ok_q[0];
				cx_q[0] <= cx_q[1]; cx_q[1] <= cx_q[2]; cx_q[2] <= cx_q[0];
				cz_q[0] <= cz_q[1]; cz_q[1] <= cz_q[2]; cz_q[2] <= cz_q[0];
			end
			default: ;
		endcase
	end

	// Port drives.
	assign cfg.ready           = 1'b1;
	assign result.valid        = out_valid_q;
	assign result.pixel_column = out_col_q;
	assign result.pixel_owner  = out_owner_q;
	assign result.pixel_depth  = out_depth_q;
	assign result.last_pixel   = out_last_q;

	stdr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	stdr_line_mem #(
		.DEPTH   (MAX_LINE_PIXELS),
		.OWNER_W (OWN_W)
	) u_line_mem (
		.clk      (clk),
		.ctl      (mem_ctl),
		.rd_addr  (mem_rd_addr),
		.wr_addr  (mem_wr_addr),
		.wr_depth (mem_wr_depth),
		.wr_owner (mem_wr_owner),
		.rd_depth (mem_rd_depth),
		.rd_owner (mem_rd_owner)
	);

endmodule

// ===== design/stdr_div.sv =====
// Shared restoring divider of the rasterizer, one quotient bit per cycle.
// Short mode gives 31 quotient bits, long mode 48. Depends on stdr_pkg.
module stdr_div import stdr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DVS_W-1:0] rem_q;
	logic [DIV_Q_W-1:0]   sh_q;
	logic [DIV_Q_W-1:0]   quo_q;
	logic [DIV_DVS_W-1:0] dvs_q;

	logic [DIV_DVS_W:0]   trial;
	logic [DIV_DVS_W:0]   diff;
	logic                 fits;

	// One trial subtraction per step.
	always_comb begin
		trial = {rem_q, sh_q[DIV_Q_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.long_mode ? DIV_CNT_W'(DIV_LONG_STEPS)
				                        : DIV_CNT_W'(DIV_SHORT_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, dividend shift register and quotient.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			quo_q <= '0;
			if (req.long_mode) begin
				rem_q <= DIV_DVS_W'(req.dividend[DIV_DVD_W-1:DIV_LONG_STEPS]);
				sh_q  <= req.dividend[DIV_LONG_STEPS-1:0];
			end else begin
				rem_q <= req.dividend[DIV_DVD_W-1:DIV_SHORT_STEPS];
				sh_q  <= {req.dividend[DIV_SHORT_STEPS-1:0],
				          (DIV_Q_W - DIV_SHORT_STEPS)'(0)};
			end
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
			sh_q  <= {sh_q[DIV_Q_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_Q_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== design/stdr_line_mem.sv =====
// Line store of the rasterizer: depth and owner of every pixel of the line,
// one write port and one registered read port. Depends on stdr_pkg.
module stdr_line_mem import stdr_pkg::*; #(
	parameter int DEPTH   = MAX_LINE_PIXELS_DEF,
	parameter int OWNER_W = TRIANGLE_ID_BITS_DEF + 1
) (
	input  logic                      clk,
	input  mem_ctl_t                  ctl,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  logic signed [COORD_W-1:0] wr_depth,
	input  logic [OWNER_W-1:0]        wr_owner,
	output logic signed [COORD_W-1:0] rd_depth,
	output logic [OWNER_W-1:0]        rd_owner
);

	logic signed [COORD_W-1:0] depth_mem [DEPTH];
	logic [OWNER_W-1:0]        owner_mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			depth_mem[wr_addr] <= wr_depth;
			owner_mem[wr_addr] <= wr_owner;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_depth <= depth_mem[rd_addr];
			rd_owner <= owner_mem[rd_addr];
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of scanline_triangle_depth_raster: a directed table, then
// random clear, draw, read and noise transactions in phases of varied line width and half scale.
// Depends on stdr_pkg, the stdr interfaces and the block's RTL.
module tb_top;
	import stdr_pkg::*;

	localparam int Q          = 65536;
	localparam int LINE_PIX   = 2048;
	localparam int CYCLE_CAP  = 6000000;
	localparam int SETTLE     = 12000;
	localparam int ACT_UNUSED = 3;

	typedef struct {
		bit [1:0]         act;
		bit signed [31:0] ly;
		bit signed [31:0] v[9];
		bit [15:0]        id;
	} raster_item_t;

	typedef struct {
		bit [10:0] col;
		bit [16:0] owner;
		bit [31:0] depth;
		bit        last;
	} pixel_t;

	typedef struct {
		raster_item_t it;
		bit           typed;
		pixel_t       px;
	} table_row_t;

	logic clk = 0;
	logic arst_n = 0;
	int   errors = 0;
	int   cycles = 0;
	int   send_idle = 20;
	int   recv_idle = 76;

	stdr_item_if   item_ch();
	stdr_result_if res_ch();
	stdr_cfg_if    cfg_ch();

	scanline_triangle_depth_raster DUT (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(res_ch), .cfg(cfg_ch)
	);

	// Local copy of the line store and registers.
	int        depth_mem[LINE_PIX];
	bit [16:0] owner_mem[LINE_PIX];
	int        px_ptr;
	bit [11:0] width_reg;
	bit [30:0] scale_reg;
	pixel_t    pending_pixels[$];

	always #5 clk = ~clk;

	// Cycle counter with a hard limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > LINE_PIX) return LINE_PIX;
		return width_reg;
	endfunction

	function automatic void clear_store();
		for (int i = 0; i < LINE_PIX; i++) begin
			depth_mem[i] = 32'h7FFF_FFFF;
			owner_mem[i] = 17'h1FFFF;
		end
		px_ptr = 0;
	endfunction

	function automatic longint unsigned mag64(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// Signed d times a Q0.30 fraction, truncated toward zero.
	function automatic longint frac_scale(longint d, longint unsigned f);
		longint unsigned m;
		m = (mag64(d) * f) >> 30;
		return (d < 0) ? -longint'(m) : longint'(m);
	endfunction

	// Where an edge crosses the scanline; a horizontal edge never crosses.
	function automatic bit edge_hit(longint y, longint ax, longint ay, longint az,
			longint bx, longint by, longint bz, output longint cx, output longint cz);
		longint n, d;
		longint unsigned f;
		n = y - ay;
		d = by - ay;
		cx = 0;
		cz = 0;
		if (d == 0) return 0;
		if (d > 0 && (n < 0 || n > d)) return 0;
		if (d < 0 && (n > 0 || n < d)) return 0;
		f = (mag64(n) << 30) / mag64(d);
		cx = ax + frac_scale(bx - ax, f);
		cz = az + frac_scale(bz - az, f);
		return 1;
	endfunction

	// Perspective depth of a crossing; zero means the pair is dropped.
	function automatic longint crossing_depth(longint cz);
		longint den;
		longint unsigned num;
		longint q;
		den = cz - Q;
		if (den <= 0 || scale_reg == 0) return 0;
		num = scale_reg;
		num = num << 16;
		q = longint'(num / longint'(den));
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return q;
	endfunction

	function automatic void span_fill(longint xa, longint za, longint xb, longint zb,
			bit [16:0] owner);
		longint beta, first, last, t, z;
		longint unsigned pos, span;
		beta = scale_reg;
		if (xa > xb) begin
			t = xa; xa = xb; xb = t;
			t = za; za = zb; zb = t;
		end
		first = -((-(xa + beta)) >>> 16);
		if (first < 0) first = 0;
		last = (xb + beta) >>> 16;
		if (last > eff_width() - 1) last = eff_width() - 1;
		for (longint j = first; j <= last; j++) begin
			if (xb == xa) begin
				z = za;
			end else begin
				pos = j * Q - (xa + beta);
				span = xb - xa;
				while (span >= 64'd1 << 33) begin
					span = span >> 1;
					pos = pos >> 1;
				end
				z = za + frac_scale(zb - za, (pos << 30) / span);
			end
			if (z < longint'(depth_mem[j])) begin
				depth_mem[j] = int'(z);
				owner_mem[j] = owner;
			end
		end
	endfunction

	function automatic void draw_triangle(raster_item_t it);
		longint cx[3], cz[3], za, zb, beta;
		bit ok[3];
		int k, nx;
		beta = scale_reg;
		for (int i = 0; i < 3; i++) begin
			k = (i + 1) % 3;
			ok[i] = edge_hit(it.ly, it.v[3*i], it.v[3*i+1], it.v[3*i+2],
				it.v[3*k], it.v[3*k+1], it.v[3*k+2], cx[i], cz[i]);
		end
		for (int i = 0; i < 3; i++) begin
			nx = (i + 1) % 3;
			if (ok[i] && ok[nx]) begin
				za = crossing_depth(cz[i]);
				zb = crossing_depth(cz[nx]);
				if (za != 0 && zb != 0)
					span_fill((beta * cx[i]) >>> 16, za, (beta * cx[nx]) >>> 16, zb,
						{1'b0, it.id});
			end
		end
	endfunction

	// Apply one accepted transaction and return the pixel a read produces.
	function automatic bit apply_action(raster_item_t it, output pixel_t px);
		int w, p;
		px = '{default: 0};
		case (it.act)
			ACT_CLEAR: begin
				clear_store();
			end
			ACT_DRAW: begin
				draw_triangle(it);
			end
			ACT_READ: begin
				w = eff_width();
				p = (px_ptr >= w) ? 0 : px_ptr;
				px.col = 11'(p);
				px.owner = owner_mem[p];
				px.depth = depth_mem[p];
				px.last = (p == w - 1);
				px_ptr = px.last ? 0 : p + 1;
				return 1;
			end
			default: ;
		endcase
		return 0;
	endfunction

	// Send one item transaction and record what it should produce.
	task automatic send_item(raster_item_t it, bit typed = 0, pixel_t typed_px = '{default: 0});
		pixel_t px;
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			item_ch.valid = 0;
		end
		@(negedge clk);
		item_ch.valid = 1;
		item_ch.action = it.act;
		item_ch.line_y = it.ly;
		item_ch.vertex0_x = it.v[0];
		item_ch.vertex0_y = it.v[1];
		item_ch.vertex0_z = it.v[2];
		item_ch.vertex1_x = it.v[3];
		item_ch.vertex1_y = it.v[4];
		item_ch.vertex1_z = it.v[5];
		item_ch.vertex2_x = it.v[6];
		item_ch.vertex2_y = it.v[7];
		item_ch.vertex2_z = it.v[8];
		item_ch.triangle_id = it.id;
		do @(posedge clk); while (!item_ch.ready);
		if (apply_action(it, px))
			pending_pixels.insert(pending_pixels.size(), typed ? typed_px : px);
	endtask

	// Wait until every expected pixel has come and the block is idle again.
	task automatic drain();
		@(negedge clk);
		item_ch.valid = 0;
		while (pending_pixels.size() != 0 || !item_ch.ready) @(posedge clk);
	endtask

	// Register write with random junk above the register width.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] value);
		bit [31:0] junk;
		junk = $urandom;
		@(negedge clk);
		cfg_ch.valid = 1;
		cfg_ch.index = idx;
		if (idx == REG_LINE_WIDTH) cfg_ch.data = {junk[31:12], value[11:0]};
		else cfg_ch.data = {junk[31], value[30:0]};
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 0;
		if (idx == REG_LINE_WIDTH) width_reg = value[11:0];
		else scale_reg = value[30:0];
	endtask

	function automatic raster_item_t make_item(bit [1:0] act, int ly,
			int x0, int y0, int z0, int x1, int y1, int z1, int x2, int y2, int z2,
			bit [15:0] id);
		raster_item_t it;
		it.act = act;
		it.ly = ly;
		it.v = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
		it.id = id;
		return it;
	endfunction

	function automatic int pick(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// A well-formed triangle near the scanline, mostly in front of the camera.
	function automatic raster_item_t random_triangle(int spread);
		raster_item_t it;
		int xc;
		it.act = ACT_DRAW;
		it.ly = pick(-Q, Q);
		xc = pick(-Q, Q);
		for (int i = 0; i < 3; i++) begin
			it.v[3*i] = xc + pick(-spread, spread);
			it.v[3*i+1] = ($urandom_range(9) == 0) ? it.ly : it.ly + pick(-Q/2, Q/2);
			it.v[3*i+2] = ($urandom_range(9) == 0) ? pick(-2*Q, Q) : pick(Q + 1, 10*Q);
		end
		it.id = $urandom;
		return it;
	endfunction

	function automatic raster_item_t random_noise();
		raster_item_t it;
		it.act = $urandom;
		it.ly = $urandom;
		for (int i = 0; i < 9; i++) it.v[i] = $urandom;
		it.id = $urandom;
		return it;
	endfunction

	// Result checker: each result transaction against the oldest expectation.
	always @(posedge clk) begin
		pixel_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel col %0d", $time, res_ch.pixel_column);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (res_ch.pixel_column !== want.col) begin
					$display("%0t: column exp %0d got %0d", $time, want.col, res_ch.pixel_column);
					errors++;
				end
				if (res_ch.pixel_owner !== want.owner) begin
					$display("%0t: owner exp %h got %h", $time, want.owner, res_ch.pixel_owner);
					errors++;
				end
				if (res_ch.pixel_depth !== want.depth) begin
					$display("%0t: depth exp %h got %h", $time, want.depth, res_ch.pixel_depth);
					errors++;
				end
				if (res_ch.last_pixel !== want.last) begin
					$display("%0t: last exp %b got %b", $time, want.last, res_ch.last_pixel);
					errors++;
				end
			end
		end
	end

	// Receiver stalls.
	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= recv_idle);

	initial begin
		table_row_t rows[$];
		raster_item_t it;
		pixel_t blank;
		int widths[9], scales[9], spreads[9];
		int r;

		item_ch.valid = 0;
		item_ch.action = ACT_CLEAR;
		item_ch.line_y = 0;
		item_ch.vertex0_x = 0;
		item_ch.vertex0_y = 0;
		item_ch.vertex0_z = 0;
		item_ch.vertex1_x = 0;
		item_ch.vertex1_y = 0;
		item_ch.vertex1_z = 0;
		item_ch.vertex2_x = 0;
		item_ch.vertex2_y = 0;
		item_ch.vertex2_z = 0;
		item_ch.triangle_id = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = REG_LINE_WIDTH;
		cfg_ch.data = 0;
		res_ch.ready = 0;
		width_reg = LINE_WIDTH_RESET;
		scale_reg = HALF_SCALE_RESET;
		clear_store();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed table at the reset register values.
		blank = '{0, 17'h1FFFF, 32'h7FFF_FFFF, 0};
		rows.insert(rows.size(),
			'{make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, blank});
		rows.insert(rows.size(), '{make_item(ACT_UNUSED, -1, -1, -1, -1, -1, -1, -1, -1,
			-1, -1, 16'hFFFF), 0, blank});
		// A horizontal edge lying on the scanline.
		rows.insert(rows.size(),
			'{make_item(ACT_DRAW, 0, -327, 0, 2*Q, 327, 0, 2*Q, 0, Q/2, 2*Q, 5), 0, blank});
		// Every crossing at one x: spans of zero width.
		rows.insert(rows.size(),
			'{make_item(ACT_DRAW, 0, 0, -Q/2, 3*Q, 0, Q/2, 3*Q, 0, Q/4, 3*Q, 7), 0, blank});
		// Depth at z of one and behind the camera: nothing is drawn.
		rows.insert(rows.size(),
			'{make_item(ACT_DRAW, 0, -600, -Q, Q, 600, Q, Q, 0, Q, Q, 9), 0, blank});
		rows.insert(rows.size(),
			'{make_item(ACT_DRAW, 0, -600, -Q, -Q, 600, Q, -3*Q, 0, Q, 0, 10), 0, blank});
		// Scanline outside the triangle.
		rows.insert(rows.size(), '{make_item(ACT_DRAW, 2*Q, -600, -Q, 2*Q, 600, Q, 2*Q, 0,
			Q, 2*Q, 11), 0, blank});
		rows.insert(rows.size(), '{make_item(ACT_DRAW, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF), 0, blank});
		rows.insert(rows.size(), '{make_item(ACT_DRAW, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 0, blank});
		// Wide-spread vertices: the span lies left of the line and is clipped away.
		rows.insert(rows.size(), '{make_item(ACT_DRAW, 0, 32'h8000_0000, -Q, 4*Q, -Q, Q,
			4*Q, -Q + 900, Q, 4*Q, 16'h8001), 0, blank});
		for (int i = 0; i < 3; i++)
			rows.insert(rows.size(),
				'{make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, blank});
		rows.insert(rows.size(),
			'{make_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, blank});
		rows.insert(rows.size(),
			'{make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, blank});
		blank.col = 1;
		rows.insert(rows.size(),
			'{make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, blank});
		foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].px);
		drain();
		repeat (SETTLE) @(posedge clk);

		// Random phases: line width, half scale and triangle x spread.
		widths  = '{16, 32, 0, 4095, 24, 20, 12, 40, 1};
		scales  = '{8*Q, 16*Q, Q, 1024*Q, 0, 32'h7FFF_FFFF, pick(6*Q, 100*Q), 20*Q, Q/2};
		spreads = '{Q/2, Q/2, Q, 2048, Q, Q, Q/4, Q/2, Q};
		for (int ph = 0; ph < 9; ph++) begin
			write_reg(REG_LINE_WIDTH, widths[ph]);
			write_reg(REG_HALF_SCALE, scales[ph]);
			case (ph % 3)
				0: begin send_idle = 20; recv_idle = 76; end
				1: begin send_idle = 76; recv_idle = 20; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			for (int n = 0; n < 140; n++) begin
				if (ph == 1 && n == 70) drain();
				r = $urandom_range(99);
				if (r < 8) it = make_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				else if (r < 45) it = random_triangle(spreads[ph]);
				else if (r < 53 && eff_width() <= 64) it = random_noise();
				else it = make_item(ACT_READ, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				send_item(it);
			end
			drain();
			repeat (SETTLE) @(posedge clk);
		end

		repeat (2000) @(posedge clk);
		if (errors == 0 && pending_pixels.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== scanline_triangle_depth_raster.f =====
design/stdr_pkg.sv
design/stdr_if.sv
design/stdr_div.sv
design/stdr_line_mem.sv
design/scanline_triangle_depth_raster.sv
tb/sv/tb_top.sv
